>>> rtl/drd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_pkg: shared types and constants of the detection row decoder
// Register indexes, stage records and small clamp helpers used by all files.
// ----------------------------------------------------------------------------
package drd_pkg;

  localparam int unsigned MaxClasses = 64;
  localparam int unsigned KpCount    = 4;
  localparam int unsigned BoxWords   = 4;
  localparam int unsigned RowCap     = 128;
  localparam int unsigned MaxDim     = 4096;
  localparam int unsigned ProdW      = 57;   // 32-bit word times 25-bit signed scale
  localparam int unsigned CfgW       = 29;
  localparam int unsigned FifoDepth  = 2;    // row records held for emission
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned KpIdxW     = $clog2(2 * KpCount);
  localparam int unsigned RankW      = $clog2(KpCount);

  // output item layout inside m_axis_tdata
  localparam int unsigned OutDataW   = 152;
  localparam int unsigned OutRankLsb = 143;
  localparam int unsigned OutBwLsb   = 61;
  localparam int unsigned OutBhLsb   = 74;

  typedef enum logic [2:0] {
    CFG_CLASS_COUNT     = 3'd0,
    CFG_ROW_LENGTH      = 3'd1,
    CFG_MIN_SCORE       = 3'd2,
    CFG_INVERSE_SCALE   = 3'd3,
    CFG_OFFSET_X        = 3'd4,
    CFG_OFFSET_Y        = 3'd5,
    CFG_IMAGE_WIDTH     = 3'd6,
    CFG_IMAGE_HEIGHT    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SLOT_NONE  = 2'd0,
    SLOT_BOX   = 2'd1,
    SLOT_POINT = 2'd2
  } slot_e;

  typedef struct packed {
    logic [6:0]  class_count;
    logic [7:0]  row_length;
    logic [16:0] min_score;
    logic [23:0] inverse_scale;
    logic [28:0] offset_x;
    logic [28:0] offset_y;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } cfg_t;

  // one accepted word after row bookkeeping
  typedef struct packed {
    logic signed [31:0] word;
    slot_e              kind;
    logic [KpIdxW-1:0]  idx;
    logic               done;   // last word of a row that is kept
    logic [5:0]         cls;
    logic [30:0]        score;
  } tap_t;

  // row end after edge mapping and keypoint ranking
  typedef struct packed {
    logic                           valid;
    logic [5:0]                     cls;
    logic [30:0]                    score;
    logic [11:0]                    left;
    logic [11:0]                    top;
    logic [23:0]                    w_pos;
    logic [23:0]                    h_pos;
    logic [KpCount-1:0][RankW-1:0]  rank;
    logic [KpCount-1:0][27:0]       px;
    logic [KpCount-1:0][27:0]       py;
  } fin_t;

  // finished row, keypoints in sorted order
  typedef struct packed {
    logic [5:0]               cls;
    logic [30:0]              score;
    logic [11:0]              left;
    logic [11:0]              top;
    logic [12:0]              bw;
    logic [12:0]              bh;
    logic [KpCount-1:0][27:0] px;
    logic [KpCount-1:0][27:0] py;
  } rec_t;

  function automatic logic [12:0] dim_clamp(logic [12:0] d);
    if (d == 13'd0) begin
      return 13'd1;
    end else if (d > 13'(MaxDim)) begin
      return 13'(MaxDim);
    end
    return d;
  endfunction

  function automatic logic [6:0] class_clamp(logic [6:0] c);
    if (c == 7'd0) begin
      return 7'd1;
    end else if (c > 7'(MaxClasses)) begin
      return 7'(MaxClasses);
    end
    return c;
  endfunction

  function automatic logic [7:0] row_len_clamp(logic [7:0] rl, logic [6:0] cc);
    logic [7:0] lo;
    logic [7:0] r;
    lo = {1'b0, cc} + 8'(BoxWords + 2 * KpCount);
    r  = (rl < lo) ? lo : rl;
    if (r > 8'(RowCap)) begin
      r = 8'(RowCap);
    end
    return r;
  endfunction

endpackage

>>> rtl/drd_row_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_row_ctrl: row position and running argmax
// Classifies each accepted word and registers it with the current best class.
// ----------------------------------------------------------------------------
module drd_row_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic signed [31:0] word_i,
  input  logic               frame_start_i,
  input  drd_pkg::cfg_t      cfg_i,
  output drd_pkg::tap_t      tap_o
);
  import drd_pkg::*;

  logic [6:0]         row_pos_q, row_pos_d, pos;
  logic signed [31:0] best_q, best_d, best_base;
  logic [5:0]         cls_q, cls_d, cls_base;
  logic [6:0]         cc;
  logic [7:0]         len, pos_ext, pos_next, score_end, point_end;
  logic               row_end, keep;
  tap_t               tap_d, tap_q;

  always_comb begin
    cc        = class_clamp(cfg_i.class_count);
    len       = row_len_clamp(cfg_i.row_length, cc);
    pos       = frame_start_i ? 7'd0 : row_pos_q;
    pos_ext   = {1'b0, pos};
    pos_next  = pos_ext + 8'd1;
    score_end = 8'(BoxWords) + {1'b0, cc};
    point_end = score_end + 8'(2 * KpCount);
    // a new row restarts the argmax at score zero, class zero
    best_base = (pos == 7'd0) ? 32'sd0 : best_q;
    cls_base  = (pos == 7'd0) ? 6'd0 : cls_q;
    best_d    = best_base;
    cls_d     = cls_base;

    tap_d.word = word_i;
    tap_d.kind = SLOT_NONE;
    tap_d.idx  = '0;
    if (pos_ext < 8'(BoxWords)) begin
      tap_d.kind = SLOT_BOX;
      tap_d.idx  = pos[KpIdxW-1:0];
    end else if (pos_ext < score_end) begin
      // strictly greater only: first maximum wins
      if (word_i > best_base) begin
        best_d = word_i;
        cls_d  = 6'(pos_ext - 8'(BoxWords));
      end
    end else if (pos_ext < point_end) begin
      tap_d.kind = SLOT_POINT;
      tap_d.idx  = KpIdxW'(pos_ext - score_end);
    end

    row_end    = pos_next >= len;
    row_pos_d  = row_end ? 7'd0 : pos_next[6:0];
    keep       = $signed({best_d[31], best_d}) >= $signed({16'b0, cfg_i.min_score});
    tap_d.done = row_end && keep;
    tap_d.cls   = cls_d;
    tap_d.score = best_d[30:0];

    if (!accept_i) begin
      tap_d.kind = SLOT_NONE;
      tap_d.done = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pos_q <= '0;
      best_q    <= '0;
      cls_q     <= '0;
    end else if (accept_i) begin
      row_pos_q <= row_pos_d;
      best_q    <= best_d;
      cls_q     <= cls_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else begin
      tap_q <= tap_d;
    end
  end

  assign tap_o = tap_q;

endmodule

>>> rtl/drd_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_scale: letterbox mapping of box and keypoint words
// Multiplies each word by the inverse scale, keeps box products and mapped
// keypoints, and at a row end forms edges and keypoint ranks.
// ----------------------------------------------------------------------------
module drd_scale (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  drd_pkg::tap_t tap_i,
  input  drd_pkg::cfg_t cfg_i,
  output logic [1:0]    busy_o,
  output drd_pkg::fin_t fin_o
);
  import drd_pkg::*;

  // product stage
  logic signed [ProdW-1:0] prod_d, prod_q;
  slot_e                   kind_q;
  logic [KpIdxW-1:0]       idx_q;
  logic                    done2_q, done3_q;
  logic [5:0]              cls2_q, cls3_q;
  logic [30:0]             score2_q, score3_q;

  // row stores
  logic signed [ProdW-1:0] box_prod_q [BoxWords];
  logic [27:0]             ptx_q [KpCount];
  logic [27:0]             pty_q [KpCount];

  logic [12:0]             iw_dim, ih_dim, pt_dim;
  logic [28:0]             pt_off;
  logic signed [57:0]      pt_sum;
  logic [27:0]             pt_hi, pt_coord;
  fin_t                    fin_d, fin_q;

  function automatic logic [11:0] box_edge(logic signed [ProdW-1:0] c,
                                           logic signed [ProdW-1:0] w,
                                           logic [28:0] off, logic [12:0] dim);
    logic signed [59:0] n;
    logic [11:0]        hi;
    // (2c - w) * inv + off * 2^17, then truncate by 2^33; below zero clamps to 0
    n  = $signed({c[ProdW-1], c[ProdW-1], c, 1'b0}) - $signed({{3{w[ProdW-1]}}, w})
       + $signed({14'b0, off, 17'b0});
    hi = 12'(dim - 13'd1);
    if (n[59]) begin
      return 12'd0;
    end else if (n[58:33] > {14'b0, hi}) begin
      return hi;
    end
    return n[44:33];
  endfunction

  assign iw_dim = dim_clamp(cfg_i.image_width);
  assign ih_dim = dim_clamp(cfg_i.image_height);
  assign prod_d = ProdW'(tap_i.word) * ProdW'($signed({1'b0, cfg_i.inverse_scale}));

  // keypoint: floor((k * inv + off * 2^16) / 2^16), clamped to the image
  always_comb begin
    pt_off = idx_q[0] ? cfg_i.offset_y : cfg_i.offset_x;
    pt_dim = idx_q[0] ? ih_dim : iw_dim;
    pt_hi  = {12'(pt_dim - 13'd1), 16'b0};
    pt_sum = $signed({prod_q[ProdW-1], prod_q}) + $signed({13'b0, pt_off, 16'b0});
    if (pt_sum[57]) begin
      pt_coord = '0;
    end else if (pt_sum[56:16] > {13'b0, pt_hi}) begin
      pt_coord = pt_hi;
    end else begin
      pt_coord = pt_sum[43:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= SLOT_NONE;
      done2_q  <= 1'b0;
      done3_q  <= 1'b0;
      idx_q    <= '0;
      prod_q   <= '0;
      cls2_q   <= '0;
      score2_q <= '0;
      cls3_q   <= '0;
      score3_q <= '0;
    end else begin
      kind_q   <= tap_i.kind;
      idx_q    <= tap_i.idx;
      done2_q  <= tap_i.done;
      prod_q   <= prod_d;
      cls2_q   <= tap_i.cls;
      score2_q <= tap_i.score;
      done3_q  <= done2_q;
      cls3_q   <= cls2_q;
      score3_q <= score2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (kind_q)
      SLOT_BOX: begin
        box_prod_q[idx_q[1:0]] <= prod_q;
      end
      SLOT_POINT: begin
        if (idx_q[0]) begin
          pty_q[idx_q[KpIdxW-1:1]] <= pt_coord;
        end else begin
          ptx_q[idx_q[KpIdxW-1:1]] <= pt_coord;
        end
      end
      default: begin
      end
    endcase
  end

  // row end: edges, raw sizes and stable ranks by x
  always_comb begin
    fin_d.valid = done3_q;
    fin_d.cls   = cls3_q;
    fin_d.score = score3_q;
    fin_d.left  = box_edge(box_prod_q[0], box_prod_q[2], cfg_i.offset_x, iw_dim);
    fin_d.top   = box_edge(box_prod_q[1], box_prod_q[3], cfg_i.offset_y, ih_dim);
    fin_d.w_pos = box_prod_q[2][ProdW-1] ? 24'd0 : box_prod_q[2][55:32];
    fin_d.h_pos = box_prod_q[3][ProdW-1] ? 24'd0 : box_prod_q[3][55:32];
    for (int i = 0; i < KpCount; i++) begin
      fin_d.px[i]   = ptx_q[i];
      fin_d.py[i]   = pty_q[i];
      fin_d.rank[i] = '0;
      for (int j = 0; j < KpCount; j++) begin
        if ((j < i && ptx_q[j] <= ptx_q[i]) || (j > i && ptx_q[j] < ptx_q[i])) begin
          fin_d.rank[i] = fin_d.rank[i] + RankW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= '0;
    end else begin
      fin_q <= fin_d;
    end
  end

  assign fin_o  = fin_q;
  assign busy_o = {1'b0, done2_q} + {1'b0, done3_q} + {1'b0, fin_q.valid};

endmodule

>>> rtl/drd_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_result: row record queue and keypoint emitter
// Clamps box sizes, orders keypoints by rank, queues rows and emits four items.
// ----------------------------------------------------------------------------
module drd_result (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  drd_pkg::fin_t                 fin_i,
  input  drd_pkg::cfg_t                 cfg_i,
  output logic [1:0]                    count_o,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [drd_pkg::OutDataW-1:0]  m_tdata_o,
  output logic                          m_tlast_o
);
  import drd_pkg::*;

  rec_t                rec_q [FifoDepth];
  rec_t                rec_d, head;
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [1:0]          count_q, count_d;
  logic [RankW-1:0]    emit_q;
  logic                push, pop, out_fire;

  function automatic logic [12:0] size_clamp(logic [23:0] raw, logic [11:0] lo_pos,
                                             logic [12:0] dim);
    logic [12:0] hi;
    hi = dim - {1'b0, lo_pos};
    if (raw == 24'd0) begin
      return 13'd1;
    end else if (raw > {11'b0, hi}) begin
      return hi;
    end
    return raw[12:0];
  endfunction

  always_comb begin
    rec_d.cls   = fin_i.cls;
    rec_d.score = fin_i.score;
    rec_d.left  = fin_i.left;
    rec_d.top   = fin_i.top;
    rec_d.bw    = size_clamp(fin_i.w_pos, fin_i.left, dim_clamp(cfg_i.image_width));
    rec_d.bh    = size_clamp(fin_i.h_pos, fin_i.top, dim_clamp(cfg_i.image_height));
    // ranks form a permutation: place each point at its rank
    for (int r = 0; r < KpCount; r++) begin
      rec_d.px[r] = '0;
      rec_d.py[r] = '0;
      for (int i = 0; i < KpCount; i++) begin
        if (fin_i.rank[i] == RankW'(r)) begin
          rec_d.px[r] = fin_i.px[i];
          rec_d.py[r] = fin_i.py[i];
        end
      end
    end
  end

  assign head       = rec_q[rd_ptr_q];
  assign m_tvalid_o = (count_q != 2'd0);
  assign m_tlast_o  = (emit_q == RankW'(KpCount - 1));
  assign out_fire   = m_tvalid_o && m_tready_i;
  assign push       = fin_i.valid;
  assign pop        = out_fire && m_tlast_o;
  assign count_d    = count_q + {1'b0, push} - {1'b0, pop};
  assign count_o    = count_q;

  assign m_tdata_o = {7'b0, emit_q, head.py[emit_q], head.px[emit_q], head.bh, head.bw,
                      head.top, head.left, head.score, head.cls};

  always_ff @(posedge clk_i) begin
    if (push) begin
      rec_q[wr_ptr_q] <= rec_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      emit_q   <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      if (out_fire) begin
        emit_q <= m_tlast_o ? '0 : emit_q + RankW'(1);
      end
    end
  end

endmodule

>>> rtl/detection_row_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_row_decoder_core: detection tensor row decoder
// Tracks row position, keeps the best class score, maps the box and keypoints
// back through the letterbox and emits four sorted keypoint items per kept row.
// ----------------------------------------------------------------------------
//
//  port group | dir | payload (lowest bit first)                | handshake
//  -----------+-----+-------------------------------------------+---------------
//  s_axis     | in  | tdata: tensor_word[31:0]; tuser: frame_start | tvalid/tready
//  m_axis     | out | tdata: class_index, score, box_left, box_top, | tvalid/tready
//             |     |   box_width, box_height, point_x, point_y,    |
//             |     |   point_rank, 7 zero bits; tlast: last_point  |
//  cfg        | in  | cfg_index_i selects, cfg_data_i holds value   | cfg_we_i
//
//  One word is taken per cycle while s_axis_tready is high. A kept row's four
//  items are queued and leave one per cycle while m_axis_tready is high.
//  A two-entry row record queue decouples the sides; s_axis_tready drops only
//  while two kept rows are queued or in flight, so it is set by output stalls.
//  Reset is asynchronous, active low; no clearing pass is needed.
//  Box and keypoint stores are written before they are read in every row.
//
module detection_row_decoder_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input words
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,   // tensor_word[31:0]
  input  logic                         s_axis_tuser,   // frame_start
  // result items
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // class_index[5:0] score[36:6] box_left[48:37] box_top[60:49]
  // box_width[73:61] box_height[86:74] point_x[114:87] point_y[142:115]
  // point_rank[144:143], zero fill [151:145]
  output logic [drd_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast,   // last_point
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_index_i,
  input  logic [drd_pkg::CfgW-1:0]     cfg_data_i
);
  import drd_pkg::*;

  cfg_t       cfg_q;
  tap_t       tap;
  fin_t       fin;
  logic [1:0] busy, fifo_count;
  logic [2:0] rows_pending;
  logic       in_accept;

  // configuration registers, written at every edge with cfg_we_i high;
  // write them only while no item is in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.class_count     <= 7'd4;
      cfg_q.row_length      <= 8'd16;
      cfg_q.min_score       <= 17'd32768;
      cfg_q.inverse_scale   <= 24'd65536;
      cfg_q.offset_x        <= '0;
      cfg_q.offset_y        <= '0;
      cfg_q.image_width     <= 13'd640;
      cfg_q.image_height    <= 13'd640;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_CLASS_COUNT:     cfg_q.class_count     <= cfg_data_i[6:0];
        CFG_ROW_LENGTH:      cfg_q.row_length      <= cfg_data_i[7:0];
        CFG_MIN_SCORE:       cfg_q.min_score       <= cfg_data_i[16:0];
        CFG_INVERSE_SCALE:   cfg_q.inverse_scale   <= cfg_data_i[23:0];
        CFG_OFFSET_X:        cfg_q.offset_x        <= cfg_data_i[28:0];
        CFG_OFFSET_Y:        cfg_q.offset_y        <= cfg_data_i[28:0];
        CFG_IMAGE_WIDTH:     cfg_q.image_width     <= cfg_data_i[12:0];
        CFG_IMAGE_HEIGHT:    cfg_q.image_height    <= cfg_data_i[12:0];
        default: begin
        end
      endcase
    end
  end

  // count every kept row between the input register and the queue; hold the
  // input once the queue could not take another one
  assign rows_pending  = {1'b0, fifo_count} + {1'b0, busy} + {2'b0, tap.done};
  assign s_axis_tready = rows_pending < 3'(FifoDepth);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  drd_row_ctrl u_row_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .word_i        ($signed(s_axis_tdata)),
    .frame_start_i (s_axis_tuser),
    .cfg_i         (cfg_q),
    .tap_o         (tap)
  );

  drd_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tap_i  (tap),
    .cfg_i  (cfg_q),
    .busy_o (busy),
    .fin_o  (fin)
  );

  drd_result u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fin_i      (fin),
    .cfg_i      (cfg_q),
    .count_o    (fifo_count),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

>>> rtl/drd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_checker: port-level checks of the detection row decoder
// Watches result items for stalls, rank order, last marking and box sizes.
// ----------------------------------------------------------------------------
module drd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [drd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);
  import drd_pkg::*;

  logic [RankW-1:0] rank;
  logic [12:0]      bw, bh;

  assign rank = m_axis_tdata[OutRankLsb +: RankW];
  assign bw   = m_axis_tdata[OutBwLsb +: 13];
  assign bh   = m_axis_tdata[OutBhLsb +: 13];

  // a stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result item changed while stalled");

  // last marks exactly the highest rank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (rank == RankW'(KpCount - 1))))
    else $error("last_point does not match point_rank");

  // inside a row the ranks follow one another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (rank == $past(rank) + RankW'(1)))
    else $error("keypoint items of a row out of order");

  // clamped box sizes never reach zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (bw != 13'd0) && (bh != 13'd0))
    else $error("box size of zero");

endmodule

bind detection_row_decoder_core drd_checker u_drd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the detection row decoder core
// Streams tensor rows under several register settings, predicts the sorted
// keypoint items of every kept row and compares each item as it leaves.
// ----------------------------------------------------------------------------
module tb;
  import drd_pkg::*;

  // one keypoint item as it appears on the output stream
  typedef struct packed {
    logic [5:0]  cls;
    logic [30:0] score;
    logic [11:0] left;
    logic [11:0] top;
    logic [12:0] bw;
    logic [12:0] bh;
    logic [27:0] px;
    logic [27:0] py;
    logic [1:0]  rank;
    logic        last;
  } point_item_t;

  typedef enum {
    MODE_TYPICAL,
    MODE_EXTREME,
    MODE_WIDE
  } cfg_mode_e;

  // Row tracker and keypoint predictor; holds the items still owed by the block.
  class keypoint_book;
    cfg_t          regs;
    int unsigned   row_pos;
    longint        box_w[BoxWords];
    longint        kp_w[2 * KpCount];
    longint        best;
    int unsigned   best_cls;
    point_item_t   pending_points[$];
    int unsigned   points_due;
    int unsigned   bad_items;

    function new();
      regs.class_count     = 7'd4;
      regs.row_length      = 8'd16;
      regs.min_score       = 17'd32768;
      regs.inverse_scale   = 24'd65536;
      regs.offset_x        = '0;
      regs.offset_y        = '0;
      regs.image_width     = 13'd640;
      regs.image_height    = 13'd640;
      row_pos    = 0;
      best       = 0;
      best_cls   = 0;
      points_due = 0;
      bad_items  = 0;
      foreach (box_w[i]) box_w[i] = 0;
      foreach (kp_w[i]) kp_w[i] = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgW-1:0] v);
      case (idx)
        CFG_CLASS_COUNT:     regs.class_count     = v[6:0];
        CFG_ROW_LENGTH:      regs.row_length      = v[7:0];
        CFG_MIN_SCORE:       regs.min_score       = v[16:0];
        CFG_INVERSE_SCALE:   regs.inverse_scale   = v[23:0];
        CFG_OFFSET_X:        regs.offset_x        = v[28:0];
        CFG_OFFSET_Y:        regs.offset_y        = v[28:0];
        CFG_IMAGE_WIDTH:     regs.image_width     = v[12:0];
        default:             regs.image_height    = v[12:0];
      endcase
    endfunction

    // score words per row after range limiting
    function int unsigned classes();
      int unsigned c;
      c = regs.class_count;
      if (c < 1) c = 1;
      if (c > MaxClasses) c = MaxClasses;
      return c;
    endfunction

    // words per row: room for box, scores and keypoints, capped at the row store
    function int unsigned row_words();
      int unsigned n;
      n = regs.row_length;
      if (n < classes() + BoxWords + 2 * KpCount) n = classes() + BoxWords + 2 * KpCount;
      if (n > RowCap) n = RowCap;
      return n;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint trunc_sh(longint n, int s);
      return (n >= 0) ? (n >>> s) : -((-n) >>> s);
    endfunction

    function longint dim_of(logic [12:0] d);
      return clip(longint'(d), 1, MaxDim);
    endfunction

    // (c - w/2) * scale + offset, truncated to whole pixels
    function longint map_edge(longint c, longint w, longint inv, longint off, longint dim);
      longint n;
      n = (2 * c - w) * inv + off * 131072;
      return clip(trunc_sh(n, 33), 0, dim - 1);
    endfunction

    // k * scale + offset, floored to Q12.16
    function longint map_point(longint k, longint inv, longint off, longint dim);
      longint n;
      n = k * inv + off * 65536;
      return clip(n >>> 16, 0, (dim - 1) * 65536);
    endfunction

    // note one accepted tensor word; queue the row's items on a kept row end
    function void take_word(logic [31:0] w, logic fs);
      int unsigned cc, len, pos;
      longint      word, inv, ox, oy, iw, ih, lft, tp, bw, bh, x, y;
      longint      px[KpCount];
      longint      py[KpCount];
      int          i, j;
      point_item_t it;
      cc   = classes();
      len  = row_words();
      pos  = fs ? 0 : row_pos;
      word = longint'($signed(w));
      if (pos == 0) begin
        best     = 0;
        best_cls = 0;
      end
      if (pos < BoxWords) begin
        box_w[pos] = word;
      end else if (pos < BoxWords + cc) begin
        // strictly greater only: the first maximum keeps the class
        if (word > best) begin
          best     = word;
          best_cls = pos - BoxWords;
        end
      end else if (pos < BoxWords + cc + 2 * KpCount) begin
        kp_w[pos - BoxWords - cc] = word;
      end
      // a position past the row end also closes the row
      if (pos + 1 < len) begin
        row_pos = pos + 1;
        return;
      end
      row_pos = 0;
      if (best < longint'(regs.min_score)) return;

      inv = longint'(regs.inverse_scale);
      ox  = longint'(regs.offset_x);
      oy  = longint'(regs.offset_y);
      iw  = dim_of(regs.image_width);
      ih  = dim_of(regs.image_height);
      lft = map_edge(box_w[0], box_w[2], inv, ox, iw);
      tp  = map_edge(box_w[1], box_w[3], inv, oy, ih);
      bw  = clip(trunc_sh(box_w[2] * inv, 32), 1, (iw - lft > 1) ? iw - lft : 1);
      bh  = clip(trunc_sh(box_w[3] * inv, 32), 1, (ih - tp > 1) ? ih - tp : 1);

      // stable insertion by x: step past strictly greater x only
      for (i = 0; i < KpCount; i++) begin
        x = map_point(kp_w[2 * i], inv, ox, iw);
        y = map_point(kp_w[2 * i + 1], inv, oy, ih);
        j = i;
        while (j > 0 && px[j - 1] > x) begin
          px[j] = px[j - 1];
          py[j] = py[j - 1];
          j--;
        end
        px[j] = x;
        py[j] = y;
      end

      for (i = 0; i < KpCount; i++) begin
        it.cls   = 6'(best_cls);
        it.score = 31'(best);
        it.left  = 12'(lft);
        it.top   = 12'(tp);
        it.bw    = 13'(bw);
        it.bh    = 13'(bh);
        it.px    = 28'(px[i]);
        it.py    = 28'(py[i]);
        it.rank  = 2'(i);
        it.last  = (i == KpCount - 1);
        pending_points = {pending_points, it};
        points_due++;
      end
    endfunction

    function string show(point_item_t p);
      return $sformatf({"cls=%0d score=%h left=%0d top=%0d w=%0d h=%0d",
                        " x=%h y=%h rank=%0d last=%0b"},
                       p.cls, p.score, p.left, p.top, p.bw, p.bh, p.px, p.py,
                       p.rank, p.last);
    endfunction

    // compare one accepted output item with the oldest owed item
    function void match_item(logic [OutDataW-1:0] d, logic tl);
      point_item_t got, want;
      got.cls   = d[5:0];
      got.score = d[36:6];
      got.left  = d[48:37];
      got.top   = d[60:49];
      got.bw    = d[73:61];
      got.bh    = d[86:74];
      got.px    = d[114:87];
      got.py    = d[142:115];
      got.rank  = d[144:143];
      got.last  = tl;
      if (pending_points.size() == 0) begin
        bad_items++;
        if (bad_items <= 10) $display("unexpected item: %s", show(got));
        return;
      end
      want = pending_points.pop_front();
      if (got != want) begin
        bad_items++;
        if (bad_items <= 10) begin
          $display("item mismatch");
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  localparam int unsigned LongHold     = 400;     // receiver hold-off in cycles
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 12;      // output latency plus queue slack

  // reset-config row: ties among the scores and among keypoint x values
  localparam logic [31:0] RowA [16] = '{
    32'h0140_8000, 32'h00F0_0000, 32'h0064_0000, 32'h0032_0000,
    32'h0000_B333, 32'h0000_E666, 32'h0000_E666, 32'hFFFF_FFFF,
    32'h012C_0000, 32'h000A_0000, 32'h0064_0000, 32'h0014_0000,
    32'h012C_0000, 32'h001E_0000, 32'h0064_0000, 32'h0028_0000
  };
  // extreme words; only negative scores, so best stays at zero
  localparam logic [31:0] RowB [13] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h8000_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000
  };

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_we_i;
  logic [2:0]          cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  keypoint_book book;
  bit           tx_gaps;
  bit           rx_gaps;
  bit           long_hold_req;
  bit           resync;          // force frame_start on the next row's first word
  int unsigned  words_sent;
  int unsigned  cycle_count;

  detection_row_decoder_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort on a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("detection_row_decoder_core test failed");
    $finish;
  end

  // Output side: check each item taken at this edge, then pick the next
  // tready. Idle in random bursts now and then; on request hold off for a
  // long stretch so the row queue fills and the input side stalls.
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        book.match_item(m_axis_tdata, m_axis_tlast);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold          = LongHold;
      end
      if (hold != 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 9);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic int unsigned pick4(int unsigned a, int unsigned b,
                                        int unsigned c, int unsigned d);
    case ($urandom_range(0, 3))
      0:       return a;
      1:       return b;
      2:       return c;
      default: return d;
    endcase
  endfunction

  function automatic cfg_t random_cfg(cfg_mode_e mode);
    cfg_t c;
    c.inverse_scale = 24'(pick4(0, 1, 65536, 24'hFF_FFFF));
    c.offset_x      = 29'(pick4(0, 1, 1 << 28, 29'h1FFF_FFFF));
    c.offset_y      = 29'(pick4(0, 1, 1 << 28, 29'h1FFF_FFFF));
    c.image_width   = 13'(pick4(0, 1, 4096, 8191));
    c.image_height  = 13'(pick4(0, 1, 4096, 8191));
    case (mode)
      MODE_EXTREME: begin
        c.class_count = 7'($urandom_range(0, 1));
        c.row_length  = 8'(pick4(0, 1, 13, 14));
        c.min_score   = 17'(pick4(0, 1, 65536, 131071));
      end
      MODE_WIDE: begin
        // over-range class count and row length: widest row the block takes
        c.class_count = 7'd127;
        c.row_length  = 8'd255;
        c.min_score   = '0;
      end
      default: begin
        c.class_count   = 7'($urandom_range(1, 6));
        c.row_length    = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 12))
                                                      : 8'(c.class_count + 12 +
                                                           $urandom_range(0, 6));
        c.min_score     = 17'($urandom_range(0, 45000));
        c.inverse_scale = 24'($urandom_range(20000, 200000));
        c.offset_x      = 29'($urandom_range(0, 100 << 16));
        c.offset_y      = 29'($urandom_range(0, 100 << 16));
        c.image_width   = 13'($urandom_range(200, 2000));
        c.image_height  = 13'($urandom_range(200, 2000));
      end
    endcase
    return c;
  endfunction

  // Plausible content for row position p; now and then a raw random word.
  function automatic logic [31:0] gen_word(int unsigned p, int unsigned cc);
    if ($urandom_range(0, 9) == 0 || p >= cc + 12) return $urandom;
    if (p < 2) return $urandom_range(0, 700 << 16);
    if (p < 4) return $urandom_range(1 << 14, 300 << 16);
    if (p < 4 + cc) begin
      case ($urandom_range(0, 3))
        0:       return pick4(16384, 32768, 49152, 65536);   // ties
        1:       return 32'(0) - 32'($urandom_range(1, 65536));
        default: return $urandom_range(0, 70000);
      endcase
    end
    if ($urandom_range(0, 3) == 0) return pick4(100 << 16, 200 << 16, 0, 32'h8000_0000);
    return 32'($urandom_range(0, 720 << 16)) - 32'(20 << 16);
  endfunction

  // Offer one word, hold it until taken, then note it.
  task automatic send_word(input logic [31:0] w, input logic fs);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    book.take_word(w, fs);
    words_sent++;
  endtask

  // Send the first n words of a row laid out for the current registers.
  task automatic send_row(input int unsigned n);
    int unsigned cc;
    logic        fs;
    cc = book.classes();
    for (int unsigned p = 0; p < n; p++) begin
      fs     = (p == 0) ? (resync | 1'($urandom_range(0, 1))) : 1'b0;
      resync = 1'b0;
      send_word(gen_word(p, cc), fs);
    end
  endtask

  // Drop valid, wait for every owed item, then let the pipeline empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (book.pending_points.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    book.set_reg(idx, v);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(CFG_CLASS_COUNT,   CfgW'(c.class_count));
    write_reg(CFG_ROW_LENGTH,    CfgW'(c.row_length));
    write_reg(CFG_MIN_SCORE,     CfgW'(c.min_score));
    write_reg(CFG_INVERSE_SCALE, CfgW'(c.inverse_scale));
    write_reg(CFG_OFFSET_X,      CfgW'(c.offset_x));
    write_reg(CFG_OFFSET_Y,      CfgW'(c.offset_y));
    write_reg(CFG_IMAGE_WIDTH,   CfgW'(c.image_width));
    write_reg(CFG_IMAGE_HEIGHT,  CfgW'(c.image_height));
    cfg_we_i <= 1'b0;
  endtask

  // Load a setting and stream rows; with noise, some rows are cut short or
  // replaced by stray words, and the next row resyncs with frame_start.
  task automatic run_phase(input cfg_t c, input int unsigned rows, input bit noise);
    int unsigned kind;
    load_config(c);
    repeat (rows) begin
      kind = noise ? $urandom_range(0, 9) : 9;
      if (kind == 0) begin
        send_row($urandom_range(1, book.row_words() - 1));
        resync = 1'b1;
      end else if (kind == 1) begin
        repeat ($urandom_range(1, 5)) send_word($urandom, 1'($urandom_range(0, 1)));
        resync = 1'b1;
      end else begin
        send_row(book.row_words());
      end
    end
    settle();
  endtask

  initial begin
    cfg_t c;
    book          = new();
    tx_gaps       = 1'b1;
    rx_gaps       = 1'b1;
    long_hold_req = 1'b0;
    resync        = 1'b1;
    words_sent    = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_CLASS_COUNT;
    cfg_data_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: first maximum wins, keypoints tie on x.
    foreach (RowA[i]) send_word(RowA[i], i == 0);
    settle();

    // Minimum row, zero threshold with only negative scores, widest scale,
    // out-of-range image sizes and extreme offsets.
    c.class_count   = 7'd1;
    c.row_length    = 8'd13;
    c.min_score     = '0;
    c.inverse_scale = 24'hFF_FFFF;
    c.offset_x      = 29'(1 << 28);
    c.offset_y      = 29'h1FFF_FFFF;
    c.image_width   = 13'd0;
    c.image_height  = 13'd8191;
    load_config(c);
    foreach (RowB[i]) send_word(RowB[i], i == 0);
    settle();

    // Extremes of every register, then one row at the full width.
    run_phase(random_cfg(MODE_EXTREME), 2, 1'b1);
    run_phase(random_cfg(MODE_EXTREME), 2, 1'b1);
    run_phase(random_cfg(MODE_WIDE), 1, 1'b0);

    // Shrink the row mid-way: the next word lies past the new row end.
    c = random_cfg(MODE_TYPICAL);
    c.class_count = 7'd8;
    c.row_length  = 8'd40;
    c.min_score   = '0;
    load_config(c);
    resync = 1'b1;
    send_row(20);
    settle();
    c.class_count = 7'd1;
    c.row_length  = 8'd13;
    load_config(c);
    send_word($urandom, 1'b0);
    resync = 1'b1;
    send_row(book.row_words());
    settle();

    // Long output stall with every row kept: fill the queue, stall the input.
    c = random_cfg(MODE_TYPICAL);
    c.min_score = '0;
    long_hold_req = 1'b1;
    run_phase(c, 3, 1'b0);

    while (words_sent < 270 || book.points_due < 48) begin
      run_phase(random_cfg(MODE_TYPICAL), $urandom_range(1, 2), 1'b1);
    end

    // Closing stretch at full rate on both sides.
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_phase(random_cfg(MODE_TYPICAL), 2, 1'b1);

    if (book.bad_items == 0 && book.pending_points.size() == 0) begin
      $display("detection_row_decoder_core test passed");
    end else begin
      $display("detection_row_decoder_core test failed");
    end
    $finish;
  end

endmodule

>>> detection_row_decoder_core.f
rtl/drd_pkg.sv
rtl/drd_row_ctrl.sv
rtl/drd_scale.sv
rtl/drd_result.sv
rtl/detection_row_decoder_core.sv
rtl/drd_checker.sv
dv/tb.sv
